>>> src/fmvg_pkg.sv
`default_nettype none

package fmvg_pkg;

    localparam int MAX_SEGMENTS  = 1024;
    localparam int MAX_DIVISIONS = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_RADIUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISION_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE     = 3'd6;

    localparam logic [15:0]        RST_TOP_RADIUS     = 16'd256;
    localparam logic [15:0]        RST_BOTTOM_RADIUS  = 16'd256;
    localparam logic [15:0]        RST_SIDE_HEIGHT    = 16'd512;
    localparam logic [10:0]        RST_SEGMENT_COUNT  = 11'd32;
    localparam logic [8:0]         RST_DIVISION_COUNT = 9'd1;
    localparam logic signed [18:0] RST_START_ANGLE    = 19'sd0;
    localparam logic signed [18:0] RST_END_ANGLE      = 19'sd65536;

    // pipelined divider geometry
    localparam int DIV_NW = 30;
    localparam int DIV_DW = 11;
    localparam int DIV_QW = 20;

    localparam int CORDIC_N = 16;
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    localparam logic [13:0] CORDIC_ATAN [0:CORDIC_N-1] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [15:0] ONE_Q14 = 16'd16384;

    typedef enum logic [2:0] {
        NS_LOAD,
        NS_SQRT,
        NS_PREP,
        NS_DIV,
        NS_DONE
    } t_norm_state;

    typedef struct packed {
        logic               busy;
        logic signed [15:0] ny;
        logic [15:0]        nxz;
    } t_norm_res;

endpackage

`default_nettype wire

>>> src/frustum_mesh_vertex_generator_core.sv
`default_nettype none

// Channel  Dir  Handshake           Payload
// vertex   in   i_valid / o_stall   i_row_index, i_column_index
// result   out  o_valid / i_stall   o_pos_*, o_normal_*, o_tex_*, o_index_clamped
// config   in   i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// One vertex per clock while o_stall is low; each passes a 20-stage divider
// for ring radius, height, angle and texture coords, then a 16-stage CORDIC.
// After reset, and after any write to a radius or the height, o_stall is high
// while the slope normal is worked out (32 sqrt + 16 divide steps).
// The pipe advances as one; a held result freezes it only once the last stage
// is full, so bubbles are squeezed out and new transactions still get in.
module frustum_mesh_vertex_generator_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [8:0]         i_row_index,
    input  wire logic [10:0]        i_column_index,

    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [16:0]      o_pos_x,
    output logic signed [16:0]      o_pos_y,
    output logic signed [16:0]      o_pos_z,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y,
    output logic signed [15:0]      o_normal_z,
    output logic [16:0]             o_tex_u,
    output logic [16:0]             o_tex_v,
    output logic                    o_index_clamped,

    input  wire logic                            i_cfg_wr_en,
    input  wire logic [fmvg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fmvg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW   = fmvg_pkg::DIV_QW;
    localparam int CN   = fmvg_pkg::CORDIC_N;
    localparam int NSTG = 3 + QW + 1 + CN + 2;

    // ---------------- configuration ----------------
    logic [15:0]        r_top_radius;
    logic [15:0]        r_bottom_radius;
    logic [15:0]        r_side_height;
    logic [10:0]        r_segment_count;
    logic [8:0]         r_division_count;
    logic signed [18:0] r_start_angle;
    logic signed [18:0] r_end_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_radius     <= fmvg_pkg::RST_TOP_RADIUS;
            r_bottom_radius  <= fmvg_pkg::RST_BOTTOM_RADIUS;
            r_side_height    <= fmvg_pkg::RST_SIDE_HEIGHT;
            r_segment_count  <= fmvg_pkg::RST_SEGMENT_COUNT;
            r_division_count <= fmvg_pkg::RST_DIVISION_COUNT;
            r_start_angle    <= fmvg_pkg::RST_START_ANGLE;
            r_end_angle      <= fmvg_pkg::RST_END_ANGLE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fmvg_pkg::CFG_TOP_RADIUS:     r_top_radius     <= i_cfg_data[15:0];
                fmvg_pkg::CFG_BOTTOM_RADIUS:  r_bottom_radius  <= i_cfg_data[15:0];
                fmvg_pkg::CFG_SIDE_HEIGHT:    r_side_height    <= i_cfg_data[15:0];
                fmvg_pkg::CFG_SEGMENT_COUNT:  r_segment_count  <= i_cfg_data[10:0];
                fmvg_pkg::CFG_DIVISION_COUNT: r_division_count <= i_cfg_data[8:0];
                fmvg_pkg::CFG_START_ANGLE:    r_start_angle    <= i_cfg_data;
                fmvg_pkg::CFG_END_ANGLE:      r_end_angle      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_norm_start;
    assign w_norm_start = i_cfg_wr_en &&
        (i_cfg_index == fmvg_pkg::CFG_TOP_RADIUS ||
         i_cfg_index == fmvg_pkg::CFG_BOTTOM_RADIUS ||
         i_cfg_index == fmvg_pkg::CFG_SIDE_HEIGHT);

    fmvg_pkg::t_norm_res w_norm;

    fmvg_norm u_norm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_norm_start),
        .i_top_radius    (r_top_radius),
        .i_bottom_radius (r_bottom_radius),
        .i_side_height   (r_side_height),
        .o_res           (w_norm)
    );

    logic [10:0] w_seg_e;
    logic [8:0]  w_div_e;

    always_comb begin
        if (r_segment_count == '0) begin
            w_seg_e = 11'd1;
        end else if (32'(r_segment_count) > fmvg_pkg::MAX_SEGMENTS) begin
            w_seg_e = 11'(fmvg_pkg::MAX_SEGMENTS);
        end else begin
            w_seg_e = r_segment_count;
        end
        if (r_division_count == '0) begin
            w_div_e = 9'd1;
        end else if (32'(r_division_count) > fmvg_pkg::MAX_DIVISIONS) begin
            w_div_e = 9'(fmvg_pkg::MAX_DIVISIONS);
        end else begin
            w_div_e = r_division_count;
        end
    end

    // ---------------- flow control ----------------
    logic [NSTG-1:0] r_vld;
    logic            r_out_v;
    logic            w_out_free;
    logic            w_adv;
    logic            w_acc;

    assign w_out_free = !r_out_v || !i_stall;
    assign w_adv      = w_out_free || !r_vld[NSTG-1];
    assign o_stall    = !w_adv || w_norm.busy;
    assign w_acc      = i_valid && !o_stall;
    assign o_valid    = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[NSTG-2:0], w_acc};
            end
            if (w_out_free) begin
                r_out_v <= r_vld[NSTG-1];
            end
        end
    end

    // ---------------- stage 1: clamp ----------------
    logic [8:0]  r1_row;
    logic [10:0] r1_col;
    logic        r1_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_row   <= (i_row_index > w_div_e) ? w_div_e : i_row_index;
            r1_col   <= (i_column_index > w_seg_e) ? w_seg_e : i_column_index;
            r1_clamp <= (i_row_index > w_div_e) || (i_column_index > w_seg_e);
        end
    end

    // ---------------- stage 2: products ----------------
    logic [8:0]         w_dr;
    logic signed [10:0] w_k;
    logic signed [19:0] w_adiff;
    logic signed [27:0] w_hs;
    logic signed [27:0] w_ks;
    logic signed [31:0] w_as;
    logic signed [31:0] w_cs;

    assign w_dr    = w_div_e - r1_row;
    assign w_k     = $signed({2'b0, w_div_e}) - $signed({1'b0, r1_row, 1'b0});
    assign w_adiff = 20'(r_end_angle) - 20'(r_start_angle);
    assign w_hs    = 28'($signed({1'b0, r_side_height}));
    assign w_ks    = 28'(w_k);
    assign w_as    = 32'(w_adiff);
    assign w_cs    = 32'($signed({1'b0, r1_col}));

    logic [25:0]        r2_prad;
    logic signed [27:0] r2_py;
    logic signed [31:0] r2_pa;
    logic [8:0]         r2_row;
    logic [10:0]        r2_col;
    logic               r2_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_prad  <= 26'(r_top_radius) * 26'(w_dr) + 26'(r_bottom_radius) * 26'(r1_row);
            r2_py    <= w_hs * w_ks;
            r2_pa    <= w_as * w_cs;
            r2_row   <= r1_row;
            r2_col   <= r1_col;
            r2_clamp <= r1_clamp;
        end
    end

    // ---------------- stage 3: magnitudes plus half divisor ----------------
    logic [27:0] w_py_abs;
    logic [31:0] w_pa_abs;

    assign w_py_abs = r2_py[27] ? 28'(-r2_py) : 28'(r2_py);
    assign w_pa_abs = r2_pa[31] ? 32'(-r2_pa) : 32'(r2_pa);

    logic [fmvg_pkg::DIV_NW-1:0] r3_n_rad;
    logic [fmvg_pkg::DIV_NW-1:0] r3_n_y;
    logic [fmvg_pkg::DIV_NW-1:0] r3_n_a;
    logic [fmvg_pkg::DIV_NW-1:0] r3_n_u;
    logic [fmvg_pkg::DIV_NW-1:0] r3_n_v;
    logic                        r3_sy;
    logic                        r3_sa;
    logic                        r3_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_n_rad <= 30'(r2_prad) + 30'(w_div_e >> 1);
            r3_n_y   <= 30'(w_py_abs) + 30'(w_div_e);
            r3_n_a   <= 30'(w_pa_abs) + 30'(w_seg_e >> 1);
            r3_n_u   <= 30'({r2_col, 16'd0}) + 30'(w_seg_e >> 1);
            r3_n_v   <= 30'({r2_row, 16'd0}) + 30'(w_div_e >> 1);
            r3_sy    <= r2_py[27];
            r3_sa    <= r2_pa[31];
            r3_clamp <= r2_clamp;
        end
    end

    // ---------------- dividers ----------------
    logic [fmvg_pkg::DIV_DW-1:0] w_den_div;
    logic [fmvg_pkg::DIV_DW-1:0] w_den_2div;
    logic [QW-1:0] w_q_rad, w_q_y, w_q_a, w_q_u, w_q_v;

    assign w_den_div  = 11'(w_div_e);
    assign w_den_2div = 11'({w_div_e, 1'b0});

    fmvg_div u_div_rad (.i_clk(i_clk), .i_en(w_adv), .i_num(r3_n_rad), .i_den(w_den_div),
                        .o_quo(w_q_rad));
    fmvg_div u_div_y   (.i_clk(i_clk), .i_en(w_adv), .i_num(r3_n_y), .i_den(w_den_2div),
                        .o_quo(w_q_y));
    fmvg_div u_div_a   (.i_clk(i_clk), .i_en(w_adv), .i_num(r3_n_a), .i_den(w_seg_e),
                        .o_quo(w_q_a));
    fmvg_div u_div_u   (.i_clk(i_clk), .i_en(w_adv), .i_num(r3_n_u), .i_den(w_seg_e),
                        .o_quo(w_q_u));
    fmvg_div u_div_v   (.i_clk(i_clk), .i_en(w_adv), .i_num(r3_n_v), .i_den(w_den_div),
                        .o_quo(w_q_v));

    logic [QW-1:0] r_d_sy;
    logic [QW-1:0] r_d_sa;
    logic [QW-1:0] r_d_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_sy    <= {r_d_sy[QW-2:0], r3_sy};
            r_d_sa    <= {r_d_sa[QW-2:0], r3_sa};
            r_d_clamp <= {r_d_clamp[QW-2:0], r3_clamp};
        end
    end

    // ---------------- post-divide: signs, angle ----------------
    logic [20:0] w_qa_s;
    logic [20:0] w_ang;

    assign w_qa_s = r_d_sa[QW-1] ? 21'(21'd0 - 21'(w_q_a)) : 21'(w_q_a);
    assign w_ang  = 21'(r_start_angle) + w_qa_s;

    logic [15:0]        r_p_rad;
    logic signed [16:0] r_p_y;
    logic [15:0]        r_p_phase;
    logic [16:0]        r_p_u;
    logic [16:0]        r_p_v;
    logic               r_p_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_rad   <= w_q_rad[15:0];
            r_p_y     <= r_d_sy[QW-1] ? 17'(17'd0 - w_q_y[16:0]) : w_q_y[16:0];
            r_p_phase <= w_ang[15:0];
            r_p_u     <= w_q_u[16:0];
            r_p_v     <= w_q_v[16:0];
            r_p_clamp <= r_d_clamp[QW-1];
        end
    end

    // ---------------- CORDIC ----------------
    logic signed [32:0] r_c_x     [CN];
    logic signed [32:0] r_c_y     [CN];
    logic signed [17:0] r_c_z     [CN];
    logic [1:0]         r_c_quad  [CN];
    logic               r_c_zero  [CN];
    logic [15:0]        r_c_rad   [CN];
    logic signed [16:0] r_c_posy  [CN];
    logic [16:0]        r_c_u     [CN];
    logic [16:0]        r_c_v     [CN];
    logic               r_c_clamp [CN];

    for (genvar k = 0; k < CN; k++) begin : g_cordic
        logic signed [32:0] x_in, y_in;
        logic signed [17:0] z_in;
        logic [1:0]         quad_in;
        logic               zero_in;
        logic [15:0]        rad_in;
        logic signed [16:0] posy_in;
        logic [16:0]        u_in, v_in;
        logic               clamp_in;
        logic signed [17:0] atan_k;

        if (k == 0) begin : g_first
            assign x_in     = fmvg_pkg::CORDIC_X0;
            assign y_in     = '0;
            assign z_in     = $signed({4'd0, r_p_phase[13:0]});
            assign quad_in  = r_p_phase[15:14];
            assign zero_in  = (r_p_phase[13:0] == '0);
            assign rad_in   = r_p_rad;
            assign posy_in  = r_p_y;
            assign u_in     = r_p_u;
            assign v_in     = r_p_v;
            assign clamp_in = r_p_clamp;
        end else begin : g_next
            assign x_in     = r_c_x[k-1];
            assign y_in     = r_c_y[k-1];
            assign z_in     = r_c_z[k-1];
            assign quad_in  = r_c_quad[k-1];
            assign zero_in  = r_c_zero[k-1];
            assign rad_in   = r_c_rad[k-1];
            assign posy_in  = r_c_posy[k-1];
            assign u_in     = r_c_u[k-1];
            assign v_in     = r_c_v[k-1];
            assign clamp_in = r_c_clamp[k-1];
        end

        assign atan_k = $signed({4'd0, fmvg_pkg::CORDIC_ATAN[k]});

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!z_in[17]) begin
                    r_c_x[k] <= x_in - (y_in >>> k);
                    r_c_y[k] <= y_in + (x_in >>> k);
                    r_c_z[k] <= z_in - atan_k;
                end else begin
                    r_c_x[k] <= x_in + (y_in >>> k);
                    r_c_y[k] <= y_in - (x_in >>> k);
                    r_c_z[k] <= z_in + atan_k;
                end
                r_c_quad[k]  <= quad_in;
                r_c_zero[k]  <= zero_in;
                r_c_rad[k]   <= rad_in;
                r_c_posy[k]  <= posy_in;
                r_c_u[k]     <= u_in;
                r_c_v[k]     <= v_in;
                r_c_clamp[k] <= clamp_in;
            end
        end
    end

    // Q2.30 -> Q1.14, halves away from zero, limited to one
    function automatic logic signed [15:0] f_cs_round(input logic signed [32:0] v);
        logic [32:0] m;
        logic [16:0] q;
        m = v[32] ? 33'(-v) : 33'(v);
        q = 17'((m + 33'd32768) >> 16);
        if (q > 17'd16384) q = 17'd16384;
        return v[32] ? 16'(16'd0 - {1'b0, q[14:0]}) : {1'b0, q[14:0]};
    endfunction

    // product / 16384, halves away from zero, saturated to +-lim
    function automatic logic [16:0] f_q14_round(input logic signed [32:0] v,
                                                input logic [16:0] lim);
        logic [32:0] m;
        logic [18:0] q;
        m = v[32] ? 33'(-v) : 33'(v);
        q = 19'((m + 33'd8192) >> 14);
        if (q > {2'b0, lim}) q = {2'b0, lim};
        return v[32] ? 17'(17'd0 - q[16:0]) : q[16:0];
    endfunction

    // ---------------- cos/sin finish ----------------
    logic signed [15:0] w_cc, w_ss;

    always_comb begin
        if (r_c_zero[CN-1]) begin
            w_cc = $signed(fmvg_pkg::ONE_Q14);
            w_ss = '0;
        end else begin
            w_cc = f_cs_round(r_c_x[CN-1]);
            w_ss = f_cs_round(r_c_y[CN-1]);
        end
    end

    logic signed [15:0] r_cs_c, r_cs_s;
    logic [15:0]        r_cs_rad;
    logic signed [16:0] r_cs_posy;
    logic [16:0]        r_cs_u, r_cs_v;
    logic               r_cs_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            unique case (r_c_quad[CN-1])
                fmvg_pkg::QUAD_0: begin r_cs_c <= w_cc;            r_cs_s <= w_ss;            end
                fmvg_pkg::QUAD_1: begin r_cs_c <= 16'(16'd0 - w_ss); r_cs_s <= w_cc;          end
                fmvg_pkg::QUAD_2: begin r_cs_c <= 16'(16'd0 - w_cc); r_cs_s <= 16'(16'd0 - w_ss); end
                fmvg_pkg::QUAD_3: begin r_cs_c <= w_ss;            r_cs_s <= 16'(16'd0 - w_cc); end
                default:          begin r_cs_c <= w_cc;            r_cs_s <= w_ss;            end
            endcase
            r_cs_rad   <= r_c_rad[CN-1];
            r_cs_posy  <= r_c_posy[CN-1];
            r_cs_u     <= r_c_u[CN-1];
            r_cs_v     <= r_c_v[CN-1];
            r_cs_clamp <= r_c_clamp[CN-1];
        end
    end

    // ---------------- multiply ----------------
    logic signed [32:0] w_rad_s;
    logic signed [32:0] w_nxz_s;

    assign w_rad_s = 33'($signed({1'b0, r_cs_rad}));
    assign w_nxz_s = 33'($signed({1'b0, w_norm.nxz}));

    logic signed [32:0] r_m_px, r_m_pz, r_m_nx, r_m_nz;
    logic signed [16:0] r_m_posy;
    logic [16:0]        r_m_u, r_m_v;
    logic               r_m_clamp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_px    <= 33'(r_cs_c) * w_rad_s;
            r_m_pz    <= 33'(r_cs_s) * w_rad_s;
            r_m_nx    <= 33'(r_cs_c) * w_nxz_s;
            r_m_nz    <= 33'(r_cs_s) * w_nxz_s;
            r_m_posy  <= r_cs_posy;
            r_m_u     <= r_cs_u;
            r_m_v     <= r_cs_v;
            r_m_clamp <= r_cs_clamp;
        end
    end

    // ---------------- output register ----------------
    logic [16:0] w_nx_full, w_nz_full;

    assign w_nx_full = f_q14_round(r_m_nx, 17'd16384);
    assign w_nz_full = f_q14_round(r_m_nz, 17'd16384);

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_vld[NSTG-1]) begin
            o_pos_x         <= f_q14_round(r_m_px, 17'd65535);
            o_pos_y         <= r_m_posy;
            o_pos_z         <= f_q14_round(r_m_pz, 17'd65535);
            o_normal_x      <= w_nx_full[15:0];
            o_normal_y      <= w_norm.ny;
            o_normal_z      <= w_nz_full[15:0];
            o_tex_u         <= r_m_u;
            o_tex_v         <= r_m_v;
            o_index_clamped <= r_m_clamp;
        end
    end

    // ---------------- checks ----------------
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm.busy |-> !w_acc)
        else $error("transaction taken while normal unit busy");

    a_full_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && r_out_v && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved under a held result");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384 &&
                     o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384))
        else $error("normal out of range");

endmodule

`default_nettype wire

>>> src/fmvg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, floor(num / den).
// The user keeps the denominator static while items are in flight (not enforced here), so it is not piped.
module fmvg_div #(
    parameter int NW = fmvg_pkg::DIV_NW,
    parameter int DW = fmvg_pkg::DIV_DW,
    parameter int QW = fmvg_pkg::DIV_QW
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [WW-1:0] sub;
        logic [WW:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign sub  = WW'(i_den) << (QW - 1 - k);
        assign diff = {1'b0, WW'(rem_in)} - {1'b0, sub};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!diff[WW]) begin
                    r_rem[k] <= NW'(diff);
                    r_quo[k] <= quo_in | (QW'(1) << (QW - 1 - k));
                end else begin
                    r_rem[k] <= rem_in;
                    r_quo[k] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

>>> src/fmvg_norm.sv
`default_nettype none

// Slope normal from the radii and height: L = isqrt(S << 28), then
// D/L and H/L in Q1.14. Runs once after reset and after each restart.
module fmvg_norm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [15:0]      i_top_radius,
    input  wire logic [15:0]      i_bottom_radius,
    input  wire logic [15:0]      i_side_height,
    output fmvg_pkg::t_norm_res   o_res
);

    fmvg_pkg::t_norm_state r_state, n_state;

    logic [15:0] r_dmag;
    logic        r_dneg;
    logic [15:0] r_h;
    logic        r_sum0;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic [31:0] r_l;
    logic [47:0] r_rd;
    logic [47:0] r_rh;
    logic [15:0] r_qd;
    logic [15:0] r_qh;

    logic signed [16:0] w_d;
    logic [15:0]        w_dmag;
    logic [32:0]        w_sum;
    logic [63:0]        w_trial;
    logic [47:0]        w_dsub;
    logic [15:0]        w_qd_sat;
    logic [15:0]        w_qh_sat;

    assign w_d     = $signed({1'b0, i_bottom_radius}) - $signed({1'b0, i_top_radius});
    assign w_dmag  = w_d[16] ? 16'(-w_d) : w_d[15:0];
    assign w_sum   = 33'(32'(w_dmag) * 32'(w_dmag)) + 33'(32'(i_side_height) * 32'(i_side_height));
    assign w_trial = r_res + r_bit;
    assign w_dsub  = 48'(r_l) << r_cnt[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmvg_pkg::NS_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = fmvg_pkg::NS_LOAD;
        end else begin
            unique case (r_state)
                fmvg_pkg::NS_LOAD: n_state = fmvg_pkg::NS_SQRT;
                fmvg_pkg::NS_SQRT: if (r_cnt == 5'd31) n_state = fmvg_pkg::NS_PREP;
                fmvg_pkg::NS_PREP: n_state = fmvg_pkg::NS_DIV;
                fmvg_pkg::NS_DIV:  if (r_cnt == 5'd0) n_state = fmvg_pkg::NS_DONE;
                fmvg_pkg::NS_DONE: n_state = fmvg_pkg::NS_DONE;
                default:           n_state = fmvg_pkg::NS_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fmvg_pkg::NS_LOAD: begin
                r_dmag <= w_dmag;
                r_dneg <= w_d[16];
                r_h    <= i_side_height;
                r_sum0 <= (w_sum == '0);
                r_v    <= 64'({w_sum, 28'd0});
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= '0;
            end
            fmvg_pkg::NS_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            fmvg_pkg::NS_PREP: begin
                r_l   <= r_res[31:0];
                r_rd  <= 48'({r_dmag, 28'd0}) + 48'(r_res[31:1]);
                r_rh  <= 48'({r_h, 28'd0}) + 48'(r_res[31:1]);
                r_qd  <= '0;
                r_qh  <= '0;
                r_cnt <= 5'd15;
            end
            fmvg_pkg::NS_DIV: begin
                if (r_rd >= w_dsub) begin
                    r_rd <= r_rd - w_dsub;
                    r_qd[r_cnt[3:0]] <= 1'b1;
                end
                if (r_rh >= w_dsub) begin
                    r_rh <= r_rh - w_dsub;
                    r_qh[r_cnt[3:0]] <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            default: ;
        endcase
    end

    assign w_qd_sat = (r_qd > fmvg_pkg::ONE_Q14) ? fmvg_pkg::ONE_Q14 : r_qd;
    assign w_qh_sat = (r_qh > fmvg_pkg::ONE_Q14) ? fmvg_pkg::ONE_Q14 : r_qh;

    // flat degenerate case: normal points straight out
    always_comb begin
        o_res.busy = (r_state != fmvg_pkg::NS_DONE);
        if (r_sum0) begin
            o_res.ny  = '0;
            o_res.nxz = fmvg_pkg::ONE_Q14;
        end else begin
            o_res.ny  = r_dneg ? 16'(16'd0 - w_qd_sat) : w_qd_sat;
            o_res.nxz = w_qh_sat;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    // register index outside the list, writes to it are dropped
    localparam logic [fmvg_pkg::CFG_IDX_W-1:0] CFG_UNLISTED = 3'd7;

    typedef struct {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [15:0] normal_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        clamped;
    } t_vertex;

    class t_vertex_board;
        longint unsigned top_r, bot_r, height, seg_cnt, div_cnt, ang_start, ang_end;
        t_vertex pending[$];
        int errors;
        int checked;

        function new();
            top_r = 256; bot_r = 256; height = 512;
            seg_cnt = 32; div_cnt = 1; ang_start = 0; ang_end = 65536;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [fmvg_pkg::CFG_IDX_W-1:0] idx,
                              logic [fmvg_pkg::CFG_DATA_W-1:0] val);
            unique case (idx)
                fmvg_pkg::CFG_TOP_RADIUS:     top_r = 64'(val[15:0]);
                fmvg_pkg::CFG_BOTTOM_RADIUS:  bot_r = 64'(val[15:0]);
                fmvg_pkg::CFG_SIDE_HEIGHT:    height = 64'(val[15:0]);
                fmvg_pkg::CFG_SEGMENT_COUNT:  seg_cnt = 64'(val[10:0]);
                fmvg_pkg::CFG_DIVISION_COUNT: div_cnt = 64'(val[8:0]);
                fmvg_pkg::CFG_START_ANGLE:    ang_start = 64'(val);
                fmvg_pkg::CFG_END_ANGLE:      ang_end = 64'(val);
                default: ;
            endcase
        endfunction

        function longint rnd_div(longint n, longint d);
            longint m;
            m = n < 0 ? -n : n;
            m = (m + d / 2) / d;
            return n < 0 ? -m : m;
        endfunction

        function longint clip(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function longint sign19(longint unsigned v);
            longint s;
            s = longint'(v & 'h7FFFF);
            if (s & 'h40000) s -= 'h80000;
            return s;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // CORDIC within the quadrant, then rotate by quadrant
        function void trig(longint unsigned phase, output longint c, output longint s);
            logic [1:0] quad;
            longint r, x, y, z, dx, dy, cc, ss;
            quad = phase[15:14];
            r = longint'(phase & 'h3FFF);
            x = 652032874; y = 0; z = r;
            if (r == 0) begin
                cc = 16384; ss = 0;
            end else begin
                for (int i = 0; i < fmvg_pkg::CORDIC_N; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx; y += dy; z -= longint'(fmvg_pkg::CORDIC_ATAN[i]);
                    end else begin
                        x += dx; y -= dy; z += longint'(fmvg_pkg::CORDIC_ATAN[i]);
                    end
                end
                cc = clip(rnd_div(x, 65536), 16384);
                ss = clip(rnd_div(y, 65536), 16384);
            end
            unique case (quad)
                fmvg_pkg::QUAD_0: begin c = cc;  s = ss;  end
                fmvg_pkg::QUAD_1: begin c = -ss; s = cc;  end
                fmvg_pkg::QUAD_2: begin c = -cc; s = -ss; end
                default: begin c = ss; s = -cc; end
            endcase
        endfunction

        function void note_vertex(logic [8:0] row_in, logic [10:0] col_in);
            longint seg, dv, row, col, st, en, rad, y, ang, c, s, d, ny, nxz;
            longint unsigned sum, l14;
            t_vertex v;
            seg = seg_cnt; dv = div_cnt;
            row = longint'(row_in); col = longint'(col_in);
            v.clamped = 1'b0;
            if (seg < 1) seg = 1;
            if (seg > fmvg_pkg::MAX_SEGMENTS) seg = fmvg_pkg::MAX_SEGMENTS;
            if (dv < 1) dv = 1;
            if (dv > fmvg_pkg::MAX_DIVISIONS) dv = fmvg_pkg::MAX_DIVISIONS;
            if (row > dv) begin row = dv; v.clamped = 1'b1; end
            if (col > seg) begin col = seg; v.clamped = 1'b1; end
            st = sign19(ang_start);
            en = sign19(ang_end);
            rad = rnd_div(longint'(top_r) * (dv - row) + longint'(bot_r) * row, dv);
            y = clip(rnd_div(longint'(height) * (dv - 2 * row), 2 * dv), 65535);
            ang = st + rnd_div((en - st) * col, seg);
            trig(longint'(ang) & 'hFFFF, c, s);
            d = longint'(bot_r) - longint'(top_r);
            sum = longint'(d * d) + height * height;
            if (sum == 0) begin
                ny = 0; nxz = 16384;
            end else begin
                l14 = root(sum << 28);
                ny = clip(rnd_div(d * 268435456, longint'(l14)), 16384);
                nxz = clip(rnd_div(longint'(height) * 268435456, longint'(l14)), 16384);
            end
            v.pos_x = 17'(clip(rnd_div(c * rad, 16384), 65535));
            v.pos_y = 17'(y);
            v.pos_z = 17'(clip(rnd_div(s * rad, 16384), 65535));
            v.normal_x = 16'(clip(rnd_div(c * nxz, 16384), 16384));
            v.normal_y = 16'(ny);
            v.normal_z = 16'(clip(rnd_div(s * nxz, 16384), 16384));
            v.tex_u = 17'(rnd_div(col * 65536, seg));
            v.tex_v = 17'(rnd_div(row * 65536, dv));
            pending = {pending, v};
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("[%0t] vertex %0d: %s got %0h want %0h", $time, checked, what, got, want);
        endtask

        task check_vertex(t_vertex got);
            t_vertex w;
            if (pending.size() == 0) begin
                report("unexpected vertex", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.pos_x !== w.pos_x) report("pos_x", got.pos_x, w.pos_x);
            if (got.pos_y !== w.pos_y) report("pos_y", got.pos_y, w.pos_y);
            if (got.pos_z !== w.pos_z) report("pos_z", got.pos_z, w.pos_z);
            if (got.normal_x !== w.normal_x) report("normal_x", got.normal_x, w.normal_x);
            if (got.normal_y !== w.normal_y) report("normal_y", got.normal_y, w.normal_y);
            if (got.normal_z !== w.normal_z) report("normal_z", got.normal_z, w.normal_z);
            if (got.tex_u !== w.tex_u) report("tex_u", got.tex_u, w.tex_u);
            if (got.tex_v !== w.tex_v) report("tex_v", got.tex_v, w.tex_v);
            if (got.clamped !== w.clamped) report("index_clamped", got.clamped, w.clamped);
            checked++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [8:0] i_row_index = 0;
    logic [10:0] i_column_index = 0;
    logic o_valid;
    logic i_stall = 0;
    logic signed [16:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [16:0] o_tex_u, o_tex_v;
    logic o_index_clamped;
    logic i_cfg_wr_en = 0;
    logic [fmvg_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [fmvg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    frustum_mesh_vertex_generator_core uut (.*);

    t_vertex_board board = new();

    int cycles = 0;
    int tx_gap_max = 18;
    int rx_gap_max = 18;
    int hold_request = 0;
    int rx_hold = 0;
    int rx_wait = 0;
    int sent = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d vertices pending", cycles,
                     board.pending.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check on accept, then work out the next stall level
    always @(posedge i_clk) begin
        t_vertex got;
        logic nxt;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.pos_x = o_pos_x; got.pos_y = o_pos_y; got.pos_z = o_pos_z;
                got.normal_x = o_normal_x; got.normal_y = o_normal_y;
                got.normal_z = o_normal_z;
                got.tex_u = o_tex_u; got.tex_v = o_tex_v;
                got.clamped = o_index_clamped;
                board.check_vertex(got);
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (hold_request > 0) begin
                rx_hold = hold_request;
                hold_request = 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                nxt = 1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                nxt = 1;
            end else begin
                nxt = 0;
            end
            i_stall <= nxt;
        end
    end

    task automatic write_reg(logic [fmvg_pkg::CFG_IDX_W-1:0] idx,
                             logic [fmvg_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_vertex(logic [8:0] row, logic [10:0] col);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_row_index <= row;
        i_column_index <= col;
        do @(posedge i_clk); while (o_stall);
        board.note_vertex(row, col);
        sent++;
    endtask

    task automatic set_geometry(int top, int bot, int h, int seg, int dv, int st, int en);
        i_valid <= 0;
        wait_drained();
        write_reg(fmvg_pkg::CFG_TOP_RADIUS, 19'(top));
        write_reg(fmvg_pkg::CFG_BOTTOM_RADIUS, 19'(bot));
        write_reg(fmvg_pkg::CFG_SIDE_HEIGHT, 19'(h));
        write_reg(fmvg_pkg::CFG_SEGMENT_COUNT, 19'(seg));
        write_reg(fmvg_pkg::CFG_DIVISION_COUNT, 19'(dv));
        write_reg(fmvg_pkg::CFG_START_ANGLE, 19'(st));
        write_reg(fmvg_pkg::CFG_END_ANGLE, 19'(en));
    endtask

    // mostly in-range grid points, some just past the count, some anywhere
    task automatic random_vertices(int n);
        int eff_seg, eff_div, row, col;
        eff_seg = board.seg_cnt < 1 ? 1 :
                  (board.seg_cnt > fmvg_pkg::MAX_SEGMENTS ? fmvg_pkg::MAX_SEGMENTS
                                                          : int'(board.seg_cnt));
        eff_div = board.div_cnt < 1 ? 1 :
                  (board.div_cnt > fmvg_pkg::MAX_DIVISIONS ? fmvg_pkg::MAX_DIVISIONS
                                                           : int'(board.div_cnt));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: row = $urandom_range(0, 511);
                1: row = eff_div + 1;
                default: row = $urandom_range(0, eff_div);
            endcase
            case ($urandom_range(0, 9))
                0: col = $urandom_range(0, 2047);
                1: col = eff_seg + 1;
                default: col = $urandom_range(0, eff_seg);
            endcase
            send_vertex(9'(row), 11'(col));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // reset geometry: corners, quadrant-aligned angles, clamped indexes
        tx_gap_max = 0;
        send_vertex(0, 0);
        send_vertex(1, 32);
        send_vertex(0, 8);
        send_vertex(1, 16);
        send_vertex(0, 24);
        send_vertex(2, 0);
        send_vertex(0, 33);
        send_vertex(511, 2047);
        send_vertex(1, 5);
        tx_gap_max = 18;
        send_vertex(0, 1);
        send_vertex(1, 31);

        // flat degenerate frustum, zero counts
        set_geometry(0, 0, 0, 0, 0, 0, 0);
        send_vertex(0, 0);
        send_vertex(1, 1);
        send_vertex(3, 4);
        // widest extremes, counts above maximum, out-of-list register
        set_geometry(65535, 0, 65535, 2047, 511, -131072, 131072);
        write_reg(CFG_UNLISTED, 19'h7FFFF);
        send_vertex(256, 1024);
        send_vertex(257, 1025);
        send_vertex(128, 512);
        send_vertex(0, 0);
        random_vertices(160);
        set_geometry(0, 65535, 65535, 1024, 256, 131072, -131072);
        send_vertex(256, 1024);
        send_vertex(0, 0);
        random_vertices(150);
        set_geometry(0, 65535, 0, 1, 1, -1, 1);
        random_vertices(60);

        // back-to-back with a long receiver hold-off so the pipe fills up
        set_geometry(12800, 3200, 25600, 3, 7, -16384, 16384);
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_request = 300;
        random_vertices(200);
        tx_gap_max = 18;
        rx_gap_max = 18;

        for (int p = 0; p < 6; p++) begin
            set_geometry($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 2047),
                         $urandom_range(0, 511), $urandom_range(0, 'h7FFFF),
                         $urandom_range(0, 'h7FFFF));
            if (p == 2) begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end else if (p == 3) begin
                tx_gap_max = 18;
                rx_gap_max = 18;
            end
            random_vertices(80);
            // sender pauses until the pipe is empty
            i_valid <= 0;
            while (board.pending.size() != 0) @(posedge i_clk);
            random_vertices(80);
        end

        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d vertices sent, %0d checked, over 12 geometries incl. degenerate,",
                 sent, board.checked);
        $display("clamped, zero and oversize counts, and long output hold-off");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/fmvg_pkg.sv
src/fmvg_div.sv
src/fmvg_norm.sv
src/frustum_mesh_vertex_generator_core.sv
tb/sv/tb_top.sv
